@@ sv/tbo_pkg.sv @@
// Shared types and constants for the triangle / box overlap test.
// No dependencies; used by tbo_div and triangle_box_overlap_test.
package tbo_pkg;

    localparam int unsigned ID_W      = 24;
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned Q_W       = 32;
    // setup stage, one stage per quotient bit, saturate stage
    localparam int unsigned DIV_STAGES = Q_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;

    localparam logic signed [Q_W-1:0] T_HIGH = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] T_LOW  = 32'sh8000_0000;

    typedef struct packed {
        logic        [ID_W-1:0]    tri_id;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_in;

    typedef struct packed {
        logic [ID_W-1:0] tri_id_out;
        logic            overlaps;
    } t_out;

endpackage

@@ sv/tbo_div.sv @@
// Pipelined signed fixed-point divider with saturation: (num << FRAC_BITS) / den.
// One restoring step per stage, stall enables per stage. Depends on tbo_pkg.
module tbo_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic [tbo_pkg::DIV_STAGES-1:0]    i_en,
    input  logic signed [32:0]                i_num,
    input  logic signed [32:0]                i_den,
    output logic signed [tbo_pkg::Q_W-1:0]    o_quo
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int HW = NW - tbo_pkg::Q_W;
    localparam int QW = tbo_pkg::Q_W;

    // stage 0 is setup, stages 1..QW are quotient steps
    logic [32:0]   r_rem [QW+1];
    logic [QW-1:0] r_dq  [QW+1];
    logic [32:0]   r_den [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];

    logic [32:0]   n_num_mag;
    logic [32:0]   n_den_mag;
    logic [NW-1:0] n_shifted;
    logic [HW-1:0] n_high;

    always_comb begin
        n_num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
        n_den_mag = i_den[32] ? 33'(-i_den) : 33'(i_den);
        n_shifted = {n_num_mag, {FRAC_BITS{1'b0}}};
        n_high    = n_shifted[NW-1:QW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= 33'(n_high);
            r_dq[0]  <= n_shifted[QW-1:0];
            r_den[0] <= n_den_mag;
            r_neg[0] <= i_num[32] ^ i_den[32];
            // quotient would not fit in QW bits
            r_ovf[0] <= (34'(n_high) >= {1'b0, n_den_mag});
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [33:0] w_trial;
        logic        w_ge;
        always_comb begin
            w_trial = {r_rem[s-1], r_dq[s-1][QW-1]};
            w_ge    = (w_trial >= {1'b0, r_den[s-1]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= w_ge ? 33'(w_trial - {1'b0, r_den[s-1]}) : w_trial[32:0];
                r_dq[s]  <= {r_dq[s-1][QW-2:0], w_ge};
                r_den[s] <= r_den[s-1];
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    logic [QW-1:0] w_q;
    logic signed [QW-1:0] n_quo;

    always_comb begin
        w_q = r_dq[QW];
        if (!r_neg[QW]) begin
            n_quo = (r_ovf[QW] || w_q[QW-1]) ? tbo_pkg::T_HIGH : $signed(w_q);
        end else begin
            n_quo = (r_ovf[QW] || (w_q[QW-1] && (|w_q[QW-2:0]))) ? tbo_pkg::T_LOW
                                                                : $signed(-w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+1]) begin
            o_quo <= n_quo;
        end
    end

endmodule

@@ sv/triangle_box_overlap_test.sv @@
// Triangle versus axis-aligned box overlap test, top level.
// Depends on tbo_pkg and tbo_div (36 divider lanes).
//
//  channel | valid      | ready       | payload
//  in      | i_in_valid | o_in_ready  | i_in  (tbo_pkg::t_in)
//  out     | o_out_valid| i_out_ready | o_out (tbo_pkg::t_out)
//  cfg     | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; 38 register stages:
// difference stage, 34-stage divider (setup, one stage per quotient bit,
// saturation), slab ordering, ray evaluation, output register.
// Reset is synchronous: clears the stage valid bits and the box registers.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse while the output is stalled. Config is always ready.
module triangle_box_overlap_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tbo_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tbo_pkg::t_out                     o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbo_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tbo_pkg::COORD_W-1:0]       i_cfg_data
);

    localparam int DS     = tbo_pkg::DIV_STAGES;
    localparam int ST_ORD = DS + 1;
    localparam int ST_RAY = DS + 2;
    localparam int ST_OUT = DS + 3;
    localparam int NST    = DS + 4;

    // rays AB, BA, BC, CB, CA, AC
    localparam logic [1:0] RAY_O [6] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0};
    localparam logic [1:0] RAY_E [6] = '{2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2};

    typedef struct packed {
        logic [tbo_pkg::ID_W-1:0] id;
        logic                     vtx_in;
        logic [17:0]              zero;
        logic [5:0]               zmiss;
    } t_side;

    // ---------------- configuration ----------------
    logic signed [31:0] r_box_min [3];
    logic signed [31:0] r_box_max [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_box_min[k] <= '0;
                r_box_max[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tbo_pkg::CFG_BOX_MIN_X: r_box_min[0] <= $signed(i_cfg_data);
                tbo_pkg::CFG_BOX_MIN_Y: r_box_min[1] <= $signed(i_cfg_data);
                tbo_pkg::CFG_BOX_MIN_Z: r_box_min[2] <= $signed(i_cfg_data);
                tbo_pkg::CFG_BOX_MAX_X: r_box_max[0] <= $signed(i_cfg_data);
                tbo_pkg::CFG_BOX_MAX_Y: r_box_max[1] <= $signed(i_cfg_data);
                tbo_pkg::CFG_BOX_MAX_Z: r_box_max[2] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;

    assign adv[NST-1] = !r_v[NST-1] || i_out_ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_adv
        assign adv[k] = !r_v[k] || adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_v[NST-1];

    // ---------------- stage 0: differences and range checks ----------------
    logic signed [31:0] vtx [3][3];
    logic signed [32:0] n_num [6][3][2];
    logic signed [32:0] n_den [6][3];
    t_side              n_side;
    logic               w_oor;
    logic [2:0]         w_vin;

    always_comb begin
        vtx[0][0] = i_in.a_x; vtx[0][1] = i_in.a_y; vtx[0][2] = i_in.a_z;
        vtx[1][0] = i_in.b_x; vtx[1][1] = i_in.b_y; vtx[1][2] = i_in.b_z;
        vtx[2][0] = i_in.c_x; vtx[2][1] = i_in.c_y; vtx[2][2] = i_in.c_z;
        n_side = '0;
        n_side.id = i_in.tri_id;
        for (int p = 0; p < 3; p++) begin
            w_vin[p] = 1'b1;
            for (int k = 0; k < 3; k++) begin
                if (vtx[p][k] < r_box_min[k] || vtx[p][k] > r_box_max[k]) begin
                    w_vin[p] = 1'b0;
                end
            end
        end
        n_side.vtx_in = |w_vin;
        for (int r = 0; r < 6; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_den[r][k] = {vtx[RAY_E[r]][k][31], vtx[RAY_E[r]][k]}
                            - {vtx[RAY_O[r]][k][31], vtx[RAY_O[r]][k]};
                n_num[r][k][0] = {r_box_min[k][31], r_box_min[k]}
                               - {vtx[RAY_O[r]][k][31], vtx[RAY_O[r]][k]};
                n_num[r][k][1] = {r_box_max[k][31], r_box_max[k]}
                               - {vtx[RAY_O[r]][k][31], vtx[RAY_O[r]][k]};
                w_oor = (vtx[RAY_O[r]][k] < r_box_min[k])
                     || (vtx[RAY_O[r]][k] > r_box_max[k]);
                n_side.zero[r*3+k] = (n_den[r][k] == '0);
                // zero direction with origin outside the slab misses the ray
                if (n_side.zero[r*3+k] && w_oor) begin
                    n_side.zmiss[r] = 1'b1;
                end
            end
        end
    end

    logic signed [32:0] r_num [6][3][2];
    logic signed [32:0] r_den [6][3];
    t_side              r_side [DS+1];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_num     <= n_num;
            r_den     <= n_den;
            r_side[0] <= n_side;
        end
        for (int k = 1; k <= DS; k++) begin
            if (adv[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- divider lanes ----------------
    logic signed [31:0] w_quo [18][2];

    for (genvar r = 0; r < 6; r++) begin : g_ray
        for (genvar k = 0; k < 3; k++) begin : g_axis
            for (genvar b = 0; b < 2; b++) begin : g_bound
                tbo_div #(.FRAC_BITS(FRAC_BITS)) u_div (
                    .i_clk (i_clk),
                    .i_en  (adv[DS:1]),
                    .i_num (r_num[r][k][b]),
                    .i_den (r_den[r][k]),
                    .o_quo (w_quo[r*3+k][b])
                );
            end
        end
    end

    // ---------------- slab ordering ----------------
    logic signed [31:0] r_a [18];
    logic signed [31:0] r_b [18];
    t_side              r_side_ord;

    always_ff @(posedge i_clk) begin
        if (adv[ST_ORD]) begin
            r_side_ord <= r_side[DS];
            for (int j = 0; j < 18; j++) begin
                if (r_side[DS].zero[j]) begin
                    r_a[j] <= tbo_pkg::T_LOW;
                    r_b[j] <= tbo_pkg::T_HIGH;
                end else if (w_quo[j][0] > w_quo[j][1]) begin
                    r_a[j] <= w_quo[j][1];
                    r_b[j] <= w_quo[j][0];
                end else begin
                    r_a[j] <= w_quo[j][0];
                    r_b[j] <= w_quo[j][1];
                end
            end
        end
    end

    // ---------------- ray evaluation ----------------
    // A ray hits when the latest entry is positive and not past the earliest exit.
    logic signed [31:0] w_lo [6];
    logic signed [31:0] w_hi [6];
    logic [5:0]         n_ray;

    always_comb begin
        for (int r = 0; r < 6; r++) begin
            w_lo[r] = r_a[r*3];
            w_hi[r] = r_b[r*3];
            for (int k = 1; k < 3; k++) begin
                if (r_a[r*3+k] > w_lo[r]) w_lo[r] = r_a[r*3+k];
                if (r_b[r*3+k] < w_hi[r]) w_hi[r] = r_b[r*3+k];
            end
            n_ray[r] = !r_side_ord.zmiss[r] && (w_lo[r] > 0) && (w_lo[r] <= w_hi[r]);
        end
    end

    logic [5:0]               r_ray;
    logic [tbo_pkg::ID_W-1:0] r_id_ray;
    logic                     r_vtx_in_ray;

    always_ff @(posedge i_clk) begin
        if (adv[ST_RAY]) begin
            r_ray        <= n_ray;
            r_id_ray     <= r_side_ord.id;
            r_vtx_in_ray <= r_side_ord.vtx_in;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (adv[ST_OUT]) begin
            o_out.tri_id_out <= r_id_ray;
            o_out.overlaps   <= r_vtx_in_ray || (r_ray[0] && r_ray[1])
                             || (r_ray[2] && r_ray[3]) || (r_ray[4] && r_ray[5]);
        end
    end

    // ---------------- assertions ----------------
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked while output stage is empty");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input blocked while output is being taken");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ST_RAY] && !o_out_valid) |=> o_out_valid)
        else $error("item lost between ray stage and output");

endmodule

@@ bench/tbo_checker.sv @@
// Checker for the triangle / box overlap test: watches the config, input and output
// channels, predicts each result and compares. Depends on tbo_pkg.
`timescale 1ns / 100ps
module tbo_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  tbo_pkg::t_in                  i_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  tbo_pkg::t_out                 i_out,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [tbo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbo_pkg::COORD_W-1:0]   i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    localparam longint P_HIGH = 64'sd2147483647;
    localparam longint P_LOW  = -64'sd2147483648;

    longint        box_min[3];
    longint        box_max[3];
    tbo_pkg::t_out expected_q[$];

    function automatic longint slab_t(longint num, longint den);
        longint q;
        q = (num * (64'sd1 <<< FRAC_BITS)) / den;
        if (q > P_HIGH) q = P_HIGH;
        if (q < P_LOW) q = P_LOW;
        return q;
    endfunction

    function automatic bit vertex_in_box(longint p[3]);
        for (int i = 0; i < 3; i++)
            if (p[i] < box_min[i] || p[i] > box_max[i]) return 0;
        return 1;
    endfunction

    function automatic bit ray_enters(longint o[3], longint e[3]);
        longint lo, hi, d, a, b, t;
        lo = P_LOW;
        hi = P_HIGH;
        for (int i = 0; i < 3; i++) begin
            d = e[i] - o[i];
            if (d == 0) begin
                if (o[i] < box_min[i] || o[i] > box_max[i]) return 0;
                a = P_LOW;
                b = P_HIGH;
            end else begin
                a = slab_t(box_min[i] - o[i], d);
                b = slab_t(box_max[i] - o[i], d);
                if (a > b) begin
                    t = a; a = b; b = t;
                end
            end
            if (a > hi || lo > b) return 0;
            if (a > lo) lo = a;
            if (b < hi) hi = b;
        end
        return (lo <= hi) && lo > 0 && hi > 0;
    endfunction

    function automatic bit edge_crosses(longint p[3], longint q[3]);
        return ray_enters(p, q) && ray_enters(q, p);
    endfunction

    function automatic tbo_pkg::t_out overlap_result(tbo_pkg::t_in t);
        longint va[3], vb[3], vc[3];
        tbo_pkg::t_out r;
        va = '{longint'(t.a_x), longint'(t.a_y), longint'(t.a_z)};
        vb = '{longint'(t.b_x), longint'(t.b_y), longint'(t.b_z)};
        vc = '{longint'(t.c_x), longint'(t.c_y), longint'(t.c_z)};
        r.tri_id_out = t.tri_id;
        r.overlaps = vertex_in_box(va) || vertex_in_box(vb) || vertex_in_box(vc)
                  || edge_crosses(va, vb) || edge_crosses(vb, vc)
                  || edge_crosses(vc, va);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        tbo_pkg::t_out exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                box_min[i] = 0;
                box_max[i] = 0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < tbo_pkg::CFG_BOX_MAX_X)
                    box_min[i_cfg_index] = longint'($signed(i_cfg_data));
                else if (i_cfg_index <= tbo_pkg::CFG_BOX_MAX_Z)
                    box_max[i_cfg_index - tbo_pkg::CFG_BOX_MAX_X] =
                        longint'($signed(i_cfg_data));
            end
            if (i_in_valid && i_in_ready)
                expected_q = {expected_q, overlap_result(i_in)};
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item id %0h", i_out.tri_id_out));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_out.tri_id_out !== exp_r.tri_id_out)
                        report_mismatch($sformatf("tri_id_out %0h, want %0h",
                            i_out.tri_id_out, exp_r.tri_id_out));
                    if (i_out.overlaps !== exp_r.overlaps)
                        report_mismatch($sformatf("id %0h overlaps %0b, want %0b",
                            exp_r.tri_id_out, i_out.overlaps, exp_r.overlaps));
                end
            end
            o_pending = expected_q.size();
        end
    end
endmodule

@@ bench/testbench.sv @@
// Top of the overlap test bench: clock, reset, stimulus and verdict.
// Depends on tbo_pkg, triangle_box_overlap_test and tbo_checker.
`timescale 1ns / 100ps
module testbench;

    localparam int LATENCY = 38;
    localparam int CYCLE_LIMIT = 400000;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          in_valid = 0;
    logic          in_ready;
    tbo_pkg::t_in  in_item = '0;
    logic          out_valid;
    logic          out_ready = 0;
    tbo_pkg::t_out out_item;
    logic          cfg_valid = 0;
    logic          cfg_ready;
    logic [tbo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tbo_pkg::COORD_W-1:0]   cfg_data = '0;
    int            errors, pending;
    int            cycles = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    bit            hold_off = 0;
    logic signed [31:0] bmin[3], bmax[3];

    always #2 i_clk = ~i_clk;

    triangle_box_overlap_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tbo_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("triangle_box_overlap_test test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk)
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    task automatic write_reg(input logic [tbo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic set_box(input logic signed [31:0] x0, y0, z0, x1, y1, z1);
        bmin = '{x0, y0, z0};
        bmax = '{x1, y1, z1};
        write_reg(tbo_pkg::CFG_BOX_MIN_X, x0);
        write_reg(tbo_pkg::CFG_BOX_MIN_Y, y0);
        write_reg(tbo_pkg::CFG_BOX_MIN_Z, z0);
        write_reg(tbo_pkg::CFG_BOX_MAX_X, x1);
        write_reg(tbo_pkg::CFG_BOX_MAX_Y, y1);
        write_reg(tbo_pkg::CFG_BOX_MAX_Z, z1);
        write_reg(3'd6 + 3'($urandom_range(1)), $urandom);  // ignored index
        cfg_valid <= 0;
    endtask

    task automatic send_tri(input tbo_pkg::t_in t);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 0;
            @(posedge i_clk);
        end
        in_valid <= 1;
        in_item  <= t;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic wait_drain();
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // coordinate near the box on one axis, sometimes anywhere
    function automatic logic [31:0] near_coord(int ax);
        longint lo, hi, v;
        lo = longint'(bmin[ax]);
        hi = longint'(bmax[ax]);
        case ($urandom_range(9))
            0: return $urandom;
            1: return bmin[ax];
            2: return bmax[ax];
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: begin
                if (lo > hi) begin v = lo; lo = hi; hi = v; end
                v = lo + longint'($urandom) % (hi - lo + 1) * (($urandom_range(1)) ? 1 : 1);
                v = v + longint'($signed($urandom)) / (64'sd1 << $urandom_range(31, 1));
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                return v[31:0];
            end
        endcase
    endfunction

    function automatic tbo_pkg::t_in rand_tri();
        tbo_pkg::t_in t;
        t.tri_id = $urandom;
        t.a_x = near_coord(0); t.a_y = near_coord(1); t.a_z = near_coord(2);
        t.b_x = near_coord(0); t.b_y = near_coord(1); t.b_z = near_coord(2);
        t.c_x = near_coord(0); t.c_y = near_coord(1); t.c_z = near_coord(2);
        case ($urandom_range(7))
            0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end  // degenerate edge
            1: t.c_x = t.b_x;                                        // zero direction
            2: begin t.a_y = t.c_y; t.a_z = t.c_z; end
            default: ;
        endcase
        return t;
    endfunction

    function automatic tbo_pkg::t_in make_tri(input logic [23:0] id,
                                              input logic [31:0] ax, ay, az,
                                              bx, by, bz, cx, cy, cz);
        tbo_pkg::t_in t;
        t = '{id, ax, ay, az, bx, by, bz, cx, cy, cz};
        return t;
    endfunction

    initial begin
        logic [31:0] one, mn, mx;
        one = 32'h0001_0000;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: unit box
        set_box(0, 0, 0, one, one, one);
        send_tri(make_tri(24'h0, 0, 0, 0, mx, mx, mx, mn, mn, mn));       // vertex on min corner
        send_tri(make_tri(24'hFFFFFF, one, one, one, mx, 0, 0, 0, mx, 0)); // vertex on max corner
        send_tri(make_tri(24'h1, -one, 32'h8000, 32'h8000, 2*one, 32'h8000, 32'h8000,
                          -one, 32'h8000, 32'h8000));                     // edge through box
        send_tri(make_tri(24'h2, -one, 2*one, 0, 2*one, 2*one, 0, 2*one, 2*one, one)); // miss
        send_tri(make_tri(24'h3, 5*one, 5*one, 5*one, 5*one, 5*one, 5*one,
                          5*one, 5*one, 5*one));                          // degenerate
        send_tri(make_tri(24'h4, mn, mn, mn, mx, mx, mx, mn, mx, mn));    // extreme span
        send_tri(make_tri(24'h5, mx, mx, mx, mx, mx, mx, mn, mn, mn));
        send_tri(make_tri(24'h6, -one, -one, -one, 2*one, 2*one, 2*one,
                          3*one, -one, 7*one));                           // diagonal edge
        send_tri(make_tri(24'h7, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000));
        send_tri(make_tri(24'h8, 2*one, 32'h8000, 32'h8000, 3*one, 32'h8000, 32'h8000,
                          4*one, 32'h8000, 32'h8000));                    // collinear, outside
        wait_drain();
        // inverted box
        set_box(one, one, one, 0, 0, 0);
        send_tri(make_tri(24'h9, 32'h8000, 32'h8000, 32'h8000, -one, 32'h8000, 32'h8000,
                          2*one, 32'h8000, 32'h8000));
        send_tri(make_tri(24'hA, -one, -one, -one, 2*one, 2*one, 2*one, 0, 0, 0));
        wait_drain();
        // whole space and tiny box
        set_box(mn, mn, mn, mx, mx, mx);
        send_tri(make_tri(24'hB, mn, mx, 0, mx, mn, 0, 0, 0, mx));
        wait_drain();
        set_box(0, 0, 0, 0, 0, 0);
        send_tri(make_tri(24'hC, -1, -1, -1, 1, 1, 1, mx, mn, 0));
        send_tri(make_tri(24'hD, mn, 0, 0, mx, 0, 0, 0, mx, mx));
        wait_drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            logic signed [31:0] lo3[3], hi3[3];
            int sz;
            for (int i = 0; i < 3; i++) begin
                sz = (ph == 7) ? 0 : $urandom_range(1 << 20);
                lo3[i] = $signed($urandom) >>> $urandom_range(12);
                hi3[i] = (ph == 6) ? lo3[i] - sz : lo3[i] + sz;
                if (ph == 5) begin lo3[i] = mn; hi3[i] = mx; end
            end
            set_box(lo3[0], lo3[1], lo3[2], hi3[0], hi3[1], hi3[2]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 66; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 66; end
                default: begin idle_pct = 37; stall_pct <= 37; end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_off <= 1;
                        repeat (300) @(posedge i_clk);
                        hold_off <= 0;
                    end
                join_none
            end
            for (int n = 0; n < 105; n++) send_tri(rand_tri());
            wait_drain();
        end
        idle_pct = 0;
        stall_pct <= 0;
        wait_drain();

        if (errors == 0)
            $display("triangle_box_overlap_test test passed");
        else
            $display("triangle_box_overlap_test test failed");
        $finish;
    end
endmodule
